// ===== rtl/core/owm_pkg.sv =====
// shared types, constants and helpers of the one-wire bus master
package owm_pkg;

    localparam int TIMER_BITS    = 10;
    localparam int BITS_PER_BYTE = 8;
    localparam int CFG_BITS      = 10;
    localparam int CFG_IDX_BITS  = 4;
    localparam int DATA_BITS     = 8;
    localparam int MODE_BITS     = 3;
    localparam int CNT_BITS      = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int TIMER_MAX     = (1 << TIMER_BITS) - 1;

    localparam logic [CFG_BITS-1:0] RESET_LOW_DEF      = 10'd500;
    localparam logic [CFG_BITS-1:0] PRESENCE_SAMPLE_DEF = 10'd50;
    localparam logic [CFG_BITS-1:0] RESET_TAIL_DEF     = 10'd200;
    localparam logic [CFG_BITS-1:0] WRITE_LOW_DEF      = 10'd4;
    localparam logic [CFG_BITS-1:0] WRITE_HOLD_DEF     = 10'd50;
    localparam logic [CFG_BITS-1:0] READ_LOW_DEF       = 10'd8;
    localparam logic [CFG_BITS-1:0] READ_SAMPLE_DEF    = 10'd14;
    localparam logic [CFG_BITS-1:0] READ_TAIL_DEF      = 10'd40;
    localparam logic [CFG_BITS-1:0] WRITE_RECOVERY_US  = 10'd4;
    localparam logic [CFG_BITS-1:0] READ_BYTE_TAIL_US  = 10'd5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RESET_LOW       = 4'd0,
        REG_PRESENCE_SAMPLE = 4'd1,
        REG_RESET_TAIL      = 4'd2,
        REG_WRITE_LOW       = 4'd3,
        REG_WRITE_HOLD      = 4'd4,
        REG_READ_LOW        = 4'd5,
        REG_READ_SAMPLE     = 4'd6,
        REG_READ_TAIL       = 4'd7
    } t_reg_idx;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_RESET    = 3'd0,
        MODE_WR_BIT   = 3'd1,
        MODE_RD_BIT   = 3'd2,
        MODE_WR_BYTE  = 3'd3,
        MODE_RD_BYTE  = 3'd4
    } t_mode;

    typedef enum logic [10:0] {
        PH_IDLE      = 11'b000_0000_0001,
        PH_RST_LOW   = 11'b000_0000_0010,
        PH_RST_WAIT  = 11'b000_0000_0100,
        PH_RST_TAIL  = 11'b000_0000_1000,
        PH_WR_LOW    = 11'b000_0001_0000,
        PH_WR_HOLD   = 11'b000_0010_0000,
        PH_WR_REC    = 11'b000_0100_0000,
        PH_RD_LOW    = 11'b000_1000_0000,
        PH_RD_WAIT   = 11'b001_0000_0000,
        PH_RD_TAIL   = 11'b010_0000_0000,
        PH_BYTE_TAIL = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic                 tick;
        logic                 cmd_valid;
        logic [MODE_BITS-1:0] mode;
        logic [DATA_BITS-1:0] cmd_byte;
        logic                 line_level;
    } t_in_item;

    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic [DATA_BITS-1:0] read_data;
        logic                 presence;
    } t_out_item;

    // one classified input beat as it travels through the queue
    typedef struct packed {
        logic                 tick;
        logic                 line_level;
        logic                 start;
        t_mode                mode;
        logic [DATA_BITS-1:0] cmd_byte;
    } t_beat;

    typedef struct packed {
        logic [CFG_BITS-1:0] reset_low;
        logic [CFG_BITS-1:0] presence_sample;
        logic [CFG_BITS-1:0] reset_tail;
        logic [CFG_BITS-1:0] write_low;
        logic [CFG_BITS-1:0] write_hold;
        logic [CFG_BITS-1:0] read_low;
        logic [CFG_BITS-1:0] read_sample;
        logic [CFG_BITS-1:0] read_tail;
    } t_cfg;

    // clamp a programmed duration to the timer range
    function automatic logic [TIMER_BITS-1:0] sat_dur(input logic [CFG_BITS-1:0] d);
        logic [31:0] w;
        w = 32'(d);
        if (w > 32'(TIMER_MAX)) begin
            sat_dur = '1;
        end else begin
            sat_dur = w[TIMER_BITS-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/owm_if.sv =====
// handshake channel interfaces of the one-wire bus master

interface owm_in_if;
    logic               valid;
    logic               ready;
    owm_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface owm_out_if;
    logic               valid;
    logic               ready;
    owm_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface owm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [owm_pkg::CFG_IDX_BITS-1:0]  idx;
    logic [owm_pkg::CFG_BITS-1:0]      data;
    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== rtl/core/one_wire_bus_master.sv =====
// top level of the one-wire bus master: front, beat queue and slot sequencer
//
//  channel   dir  payload                                         beat when
//  i_in      in   tick, cmd_valid, mode, cmd_byte, line_level     valid && ready
//  o_out     out  drive_low, busy_res, done_res, read_data,       valid && ready
//                 presence
//  i_cfg     in   idx (register index), data (10-bit value)       valid && ready
//
// one input beat a cycle while i_in.ready is high; its result shows on o_out once the beat
// has passed the queue and then the result register
// the queue holds two beats
// i_in.ready drops only when the queue is full behind a stalled o_out
// i_cfg.ready is always high; writes are meant for idle periods only
// synchronous active-low reset restores the default slot timings
module one_wire_bus_master (
    input  logic       i_clk,
    input  logic       i_rst_n,
    owm_in_if.sink     i_in,
    owm_out_if.source  o_out,
    owm_cfg_if.sink    i_cfg
);

    logic           push;
    logic           full;
    logic           q_valid;
    logic           pop;
    owm_pkg::t_beat front_beat;
    owm_pkg::t_beat q_beat;

    owm_front u_front (
        .in_ch  (i_in),
        .i_full (full),
        .o_push (push),
        .o_beat (front_beat)
    );

    owm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_beat  (front_beat),
        .o_full  (full),
        .o_valid (q_valid),
        .o_beat  (q_beat),
        .i_pop   (pop)
    );

    owm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg_ch  (i_cfg),
        .i_valid (q_valid),
        .i_beat  (q_beat),
        .o_pop   (pop),
        .out_ch  (o_out)
    );

endmodule

// ===== rtl/core/owm_front.sv =====
// input side: takes beats and classifies the command they carry
module owm_front (
    owm_in_if.sink         in_ch,
    input  logic           i_full,
    output logic           o_push,
    output owm_pkg::t_beat o_beat
);

    logic mode_ok;

    assign in_ch.ready = !i_full;
    assign o_push      = in_ch.valid && !i_full;

    always_comb begin
        case (in_ch.data.mode)
            owm_pkg::MODE_RESET,
            owm_pkg::MODE_WR_BIT,
            owm_pkg::MODE_RD_BIT,
            owm_pkg::MODE_WR_BYTE,
            owm_pkg::MODE_RD_BYTE: mode_ok = 1'b1;
            default:               mode_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_beat.tick       = in_ch.data.tick;
        o_beat.line_level = in_ch.data.line_level;
        // unknown modes are dropped here so the sequencer never sees them
        o_beat.start      = in_ch.data.cmd_valid && mode_ok;
        o_beat.mode       = owm_pkg::t_mode'(in_ch.data.mode);
        o_beat.cmd_byte   = in_ch.data.cmd_byte;
    end

endmodule

// ===== rtl/core/owm_queue.sv =====
// short queue of classified beats between front and sequencer
module owm_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  owm_pkg::t_beat         i_beat,
    output logic                   o_full,
    output logic                   o_valid,
    output owm_pkg::t_beat         o_beat,
    input  logic                   i_pop
);

    owm_pkg::t_beat                   r_mem [owm_pkg::QUEUE_DEPTH];
    logic [owm_pkg::QPTR_BITS-1:0]    r_wr_ptr, n_wr_ptr;
    logic [owm_pkg::QPTR_BITS-1:0]    r_rd_ptr, n_rd_ptr;
    logic [owm_pkg::QCNT_BITS-1:0]    r_count, n_count;

    function automatic logic [owm_pkg::QPTR_BITS-1:0] wrap_inc(
        input logic [owm_pkg::QPTR_BITS-1:0] p);
        if (32'(p) == owm_pkg::QUEUE_DEPTH - 1) begin
            wrap_inc = '0;
        end else begin
            wrap_inc = p + 1'b1;
        end
    endfunction

    assign o_full  = (32'(r_count) == owm_pkg::QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? wrap_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? wrap_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

endmodule

// ===== rtl/core/owm_back.sv =====
// slot sequencer: timing registers, slot state machine and result register
module owm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    owm_cfg_if.sink        cfg_ch,
    input  logic           i_valid,
    input  owm_pkg::t_beat i_beat,
    output logic           o_pop,
    owm_out_if.source      out_ch
);

    owm_pkg::t_cfg                      r_cfg;
    owm_pkg::t_phase                    r_phase, n_phase;
    logic [owm_pkg::TIMER_BITS-1:0]     r_timer, n_timer;
    owm_pkg::t_mode                     r_cmd_mode, n_cmd_mode;
    logic [owm_pkg::DATA_BITS-1:0]      r_shift, n_shift;
    logic [owm_pkg::CNT_BITS-1:0]       r_bit_cnt, n_bit_cnt;
    logic [owm_pkg::DATA_BITS-1:0]      r_read_shift, n_read_shift;
    logic                               r_presence, n_presence;
    logic                               n_done;
    logic                               n_drive;
    logic                               r_out_valid;
    owm_pkg::t_out_item                 r_out;
    logic [owm_pkg::CNT_BITS-1:0]       bit_inc;

    assign cfg_ch.ready = 1'b1;
    assign o_pop        = i_valid && (!r_out_valid || out_ch.ready);
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;
    assign bit_inc      = r_bit_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low       <= owm_pkg::RESET_LOW_DEF;
            r_cfg.presence_sample <= owm_pkg::PRESENCE_SAMPLE_DEF;
            r_cfg.reset_tail      <= owm_pkg::RESET_TAIL_DEF;
            r_cfg.write_low       <= owm_pkg::WRITE_LOW_DEF;
            r_cfg.write_hold      <= owm_pkg::WRITE_HOLD_DEF;
            r_cfg.read_low        <= owm_pkg::READ_LOW_DEF;
            r_cfg.read_sample     <= owm_pkg::READ_SAMPLE_DEF;
            r_cfg.read_tail       <= owm_pkg::READ_TAIL_DEF;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.idx)
                owm_pkg::REG_RESET_LOW:       r_cfg.reset_low       <= cfg_ch.data;
                owm_pkg::REG_PRESENCE_SAMPLE: r_cfg.presence_sample <= cfg_ch.data;
                owm_pkg::REG_RESET_TAIL:      r_cfg.reset_tail      <= cfg_ch.data;
                owm_pkg::REG_WRITE_LOW:       r_cfg.write_low       <= cfg_ch.data;
                owm_pkg::REG_WRITE_HOLD:      r_cfg.write_hold      <= cfg_ch.data;
                owm_pkg::REG_READ_LOW:        r_cfg.read_low        <= cfg_ch.data;
                owm_pkg::REG_READ_SAMPLE:     r_cfg.read_sample     <= cfg_ch.data;
                owm_pkg::REG_READ_TAIL:       r_cfg.read_tail       <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_timer      = r_timer;
        n_cmd_mode   = r_cmd_mode;
        n_shift      = r_shift;
        n_bit_cnt    = r_bit_cnt;
        n_read_shift = r_read_shift;
        n_presence   = r_presence;
        n_done       = 1'b0;

        if (r_phase == owm_pkg::PH_IDLE) begin
            if (i_beat.start) begin
                n_cmd_mode = i_beat.mode;
                n_shift    = i_beat.cmd_byte;
                n_bit_cnt  = '0;
                case (i_beat.mode)
                    owm_pkg::MODE_RESET: begin
                        n_presence = 1'b0;
                        n_phase    = owm_pkg::PH_RST_LOW;
                        n_timer    = owm_pkg::sat_dur(r_cfg.reset_low);
                    end
                    owm_pkg::MODE_WR_BIT, owm_pkg::MODE_WR_BYTE: begin
                        n_phase = owm_pkg::PH_WR_LOW;
                        n_timer = owm_pkg::sat_dur(r_cfg.write_low);
                    end
                    default: begin
                        n_read_shift = '0;
                        n_phase      = owm_pkg::PH_RD_LOW;
                        n_timer      = owm_pkg::sat_dur(r_cfg.read_low);
                    end
                endcase
            end
        end else if (i_beat.tick) begin
            // a timer of zero expires on its first tick, same as one
            if (r_timer > owm_pkg::TIMER_BITS'(1)) begin
                n_timer = r_timer - 1'b1;
            end else begin
                case (r_phase)
                    owm_pkg::PH_RST_LOW: begin
                        n_phase = owm_pkg::PH_RST_WAIT;
                        n_timer = owm_pkg::sat_dur(r_cfg.presence_sample);
                    end
                    owm_pkg::PH_RST_WAIT: begin
                        n_presence = !i_beat.line_level;
                        n_phase    = owm_pkg::PH_RST_TAIL;
                        n_timer    = owm_pkg::sat_dur(r_cfg.reset_tail);
                    end
                    owm_pkg::PH_WR_LOW: begin
                        n_phase = owm_pkg::PH_WR_HOLD;
                        n_timer = owm_pkg::sat_dur(r_cfg.write_hold);
                    end
                    owm_pkg::PH_WR_HOLD: begin
                        n_phase = owm_pkg::PH_WR_REC;
                        n_timer = owm_pkg::sat_dur(owm_pkg::WRITE_RECOVERY_US);
                    end
                    owm_pkg::PH_WR_REC: begin
                        n_bit_cnt = bit_inc;
                        n_shift   = r_shift >> 1;
                        if (r_cmd_mode == owm_pkg::MODE_WR_BYTE
                            && 32'(bit_inc) < owm_pkg::BITS_PER_BYTE) begin
                            n_phase = owm_pkg::PH_WR_LOW;
                            n_timer = owm_pkg::sat_dur(r_cfg.write_low);
                        end else begin
                            n_phase = owm_pkg::PH_IDLE;
                            n_timer = '0;
                            n_done  = 1'b1;
                        end
                    end
                    owm_pkg::PH_RD_LOW: begin
                        n_phase = owm_pkg::PH_RD_WAIT;
                        n_timer = owm_pkg::sat_dur(r_cfg.read_sample);
                    end
                    owm_pkg::PH_RD_WAIT: begin
                        if (i_beat.line_level) begin
                            n_read_shift[r_bit_cnt[2:0]] = 1'b1;
                        end
                        n_phase = owm_pkg::PH_RD_TAIL;
                        n_timer = owm_pkg::sat_dur(r_cfg.read_tail);
                    end
                    owm_pkg::PH_RD_TAIL: begin
                        n_bit_cnt = bit_inc;
                        if (r_cmd_mode == owm_pkg::MODE_RD_BYTE) begin
                            if (32'(bit_inc) < owm_pkg::BITS_PER_BYTE) begin
                                n_phase = owm_pkg::PH_RD_LOW;
                                n_timer = owm_pkg::sat_dur(r_cfg.read_low);
                            end else begin
                                n_phase = owm_pkg::PH_BYTE_TAIL;
                                n_timer = owm_pkg::sat_dur(owm_pkg::READ_BYTE_TAIL_US);
                            end
                        end else begin
                            n_phase = owm_pkg::PH_IDLE;
                            n_timer = '0;
                            n_done  = 1'b1;
                        end
                    end
                    owm_pkg::PH_RST_TAIL, owm_pkg::PH_BYTE_TAIL: begin
                        n_phase = owm_pkg::PH_IDLE;
                        n_timer = '0;
                        n_done  = 1'b1;
                    end
                    default: begin
                        n_phase = owm_pkg::PH_IDLE;
                        n_timer = '0;
                    end
                endcase
            end
        end

        case (n_phase)
            owm_pkg::PH_RST_LOW, owm_pkg::PH_WR_LOW, owm_pkg::PH_RD_LOW: n_drive = 1'b1;
            // early release for a one
            owm_pkg::PH_WR_HOLD: n_drive = !n_shift[0];
            default:             n_drive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= owm_pkg::PH_IDLE;
            r_timer      <= '0;
            r_cmd_mode   <= owm_pkg::MODE_RESET;
            r_shift      <= '0;
            r_bit_cnt    <= '0;
            r_read_shift <= '0;
            r_presence   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase      <= n_phase;
                r_timer      <= n_timer;
                r_cmd_mode   <= n_cmd_mode;
                r_shift      <= n_shift;
                r_bit_cnt    <= n_bit_cnt;
                r_read_shift <= n_read_shift;
                r_presence   <= n_presence;
                r_out_valid  <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.drive_low <= n_drive;
            r_out.busy_res  <= (n_phase != owm_pkg::PH_IDLE);
            r_out.done_res  <= n_done;
            r_out.read_data <= n_read_shift;
            r_out.presence  <= n_presence;
        end
    end

endmodule

// ===== rtl/core/owm_checker.sv =====
// port-level checks of the one-wire bus master and their bind
module owm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input owm_pkg::t_out_item i_out_data
);

    localparam int LIMIT = owm_pkg::QUEUE_DEPTH + 1;

    logic [3:0] r_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // beats taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_beat && !out_beat) begin
            r_pending <= r_pending + 1'b1;
        end else if (!in_beat && out_beat) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pending) <= LIMIT)
        else $error("more beats in flight than storage allows");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == '0 |-> !i_out_valid)
        else $error("result shown without an input beat");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.done_res |-> !i_out_data.busy_res && !i_out_data.drive_low)
        else $error("finished command still busy or driving");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
